/* rtl/vdpcpu_pkg.sv */
// Shared types, command codes and field widths for the video display processor CPU port.
package vdpcpu_pkg;

	localparam int VRAM_DEPTH_DEFAULT = 16384;
	localparam int PTR_W              = 14;

	// Command codes carried in the slave-side tuser.
	localparam logic [2:0] CMD_CTRL_WRITE = 3'd0;
	localparam logic [2:0] CMD_DATA_WRITE = 3'd1;
	localparam logic [2:0] CMD_DATA_READ  = 3'd2;
	localparam logic [2:0] CMD_STATUS     = 3'd3;
	localparam logic [2:0] CMD_VBLANK     = 3'd4;
	localparam logic [2:0] CMD_FIFTH      = 3'd5;

	// Action codes in the top two bits of the second control byte.
	localparam logic [1:0] OP_SET_READ  = 2'd0;
	localparam logic [1:0] OP_SET_WRITE = 2'd1;
	localparam logic [1:0] OP_REG_WRITE = 2'd2;

	// Register indexes.
	localparam logic [2:0] REG_MODE0   = 3'd0;
	localparam logic [2:0] REG_MODE1   = 3'd1;
	localparam logic [2:0] REG_NAME    = 3'd2;
	localparam logic [2:0] REG_COLOR   = 3'd3;
	localparam logic [2:0] REG_PATTERN = 3'd4;
	localparam logic [2:0] REG_ATTR    = 3'd5;
	localparam logic [2:0] REG_SPRPAT  = 3'd6;
	localparam logic [2:0] REG_COLOURS = 3'd7;

	// Decoded video modes.
	localparam logic [1:0] MODE_G1   = 2'd0;
	localparam logic [1:0] MODE_G2   = 2'd1;
	localparam logic [1:0] MODE_MC   = 2'd2;
	localparam logic [1:0] MODE_TEXT = 2'd3;

	typedef struct packed {
		logic [7:0]  mode_ctrl;   // 16K, enable, int enable, M1, M2, M3, size, magnify
		logic [24:0] raw_tables;  // R6, R5, R4, R3, R2 from the top down
		logic [7:0]  colours;     // register seven
	} vdp_regs_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [PTR_W-1:0] addr;
		logic [7:0]       wdata;
	} vram_req_t;

endpackage

/* rtl/vdp_cpu_port_interface.sv */
// Top level of the video display processor CPU port: input stage, state update, result stage.
// Each item is registered in the input stage, then in the result stage, where it waits for m_tready.
// Throughput: one transfer per cycle unless stalled; the RAM does one read or one write per cycle.
// Reads see every earlier write, since each item reaches the RAM in its own cycle and in order.
// Reset (arst_n low, asynchronous) clears the pipeline valids, pointers, registers and status.
// The video RAM is not cleared; a byte reads back undefined until it has been written.
module vdp_cpu_port_interface import vdpcpu_pkg::*; #(
	parameter int VRAM_DEPTH = VRAM_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // data_byte [7:0], sprite_number [12:8], zero [15:13]
	input  logic [2:0]  s_tuser,  // command [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data, video_mode, display_enable, interrupt_enable, name_base, pattern_base,
	// color_base, sprite_attr_base, sprite_pattern_base, sprite_size, text_color,
	// backdrop_color, from bit 0 up
	output logic [95:0] m_tdata
);

	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] data_byte_s1;
	logic [4:0] sprite_s1;
	logic       valid_s2;
	logic       vram_sel_s2;
	logic [7:0] read_byte_s2;

	logic       advance;
	logic       step;
	vdp_regs_t  regs;
	vram_req_t  vram_req;
	logic [7:0] status_read;
	logic [7:0] vram_rdata;
	logic [7:0] read_data;

	logic [1:0]       video_mode;
	logic             display_enable;
	logic             interrupt_enable;
	logic [PTR_W-1:0] name_base;
	logic [PTR_W-1:0] pattern_base;
	logic [PTR_W-1:0] color_base;
	logic [PTR_W-1:0] sprite_attr_base;
	logic [PTR_W-1:0] sprite_pattern_base;
	logic [5:0]       sprite_size;
	logic [3:0]       text_color;
	logic [3:0]       backdrop_color;

	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			command_s1   <= s_tuser;
			data_byte_s1 <= s_tdata[7:0];
			sprite_s1    <= s_tdata[12:8];
		end
		if (step) begin
			vram_sel_s2  <= (command_s1 == CMD_DATA_READ);
			read_byte_s2 <= (command_s1 == CMD_STATUS) ? status_read : 8'd0;
		end
	end

	vdpcpu_regs #(
		.VRAM_DEPTH(VRAM_DEPTH)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.command      (command_s1),
		.data_byte    (data_byte_s1),
		.sprite_number(sprite_s1),
		.regs         (regs),
		.vram_req     (vram_req),
		.status_read  (status_read)
	);

	vdpcpu_vram #(
		.VRAM_DEPTH(VRAM_DEPTH)
	) u_vram (
		.clk  (clk),
		.req  (vram_req),
		.rdata(vram_rdata)
	);

	// The registers already hold the state left by the item in the result stage.
	vdpcpu_decode u_decode (
		.regs               (regs),
		.video_mode         (video_mode),
		.display_enable     (display_enable),
		.interrupt_enable   (interrupt_enable),
		.name_base          (name_base),
		.pattern_base       (pattern_base),
		.color_base         (color_base),
		.sprite_attr_base   (sprite_attr_base),
		.sprite_pattern_base(sprite_pattern_base),
		.sprite_size        (sprite_size),
		.text_color         (text_color),
		.backdrop_color     (backdrop_color)
	);

	assign read_data = vram_sel_s2 ? vram_rdata : read_byte_s2;

	assign m_tdata = {backdrop_color, text_color, sprite_size, sprite_pattern_base,
		sprite_attr_base, color_base, pattern_base, name_base, interrupt_enable,
		display_enable, video_mode, read_data};

endmodule

/* rtl/vdpcpu_regs.sv */
// Control port decoding, pointers, display registers and status flags.
module vdpcpu_regs import vdpcpu_pkg::*; #(
	parameter int VRAM_DEPTH = VRAM_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [2:0] command,
	input  logic [7:0] data_byte,
	input  logic [4:0] sprite_number,
	output vdp_regs_t  regs,
	output vram_req_t  vram_req,
	output logic [7:0] status_read
);

	localparam int AW = $clog2(VRAM_DEPTH);

	logic             phase_q;
	logic [7:0]       latched_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [7:0]       mode_ctrl_q;
	logic [24:0]      raw_q;
	logic [7:0]       colours_q;
	logic [7:0]       status_q;

	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr_inc;
	logic [AW-1:0]    wr_addr_inc;
	logic [1:0]       op;
	logic [PTR_W-1:0] ctrl_addr;

	assign rd_addr     = rd_ptr_q[AW-1:0];
	assign wr_addr     = wr_ptr_q[AW-1:0];
	assign rd_addr_inc = rd_addr + AW'(1);
	assign wr_addr_inc = wr_addr + AW'(1);
	assign op          = data_byte[7:6];
	assign ctrl_addr   = {data_byte[5:0], latched_q};

	assign regs.mode_ctrl  = mode_ctrl_q;
	assign regs.raw_tables = raw_q;
	assign regs.colours    = colours_q;
	assign status_read     = status_q;

	always_comb begin
		vram_req.wr_en = step && (command == CMD_DATA_WRITE);
		vram_req.rd_en = step && (command == CMD_DATA_READ);
		vram_req.addr  = (command == CMD_DATA_WRITE) ? PTR_W'(wr_addr) : PTR_W'(rd_addr);
		vram_req.wdata = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			latched_q   <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			mode_ctrl_q <= '0;
			raw_q       <= '0;
			colours_q   <= '0;
			status_q    <= '0;
		end else if (step) begin
			case (command)
				CMD_CTRL_WRITE: begin
					if (!phase_q) begin
						latched_q <= data_byte;
						phase_q   <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						case (op)
							OP_SET_READ:  rd_ptr_q <= ctrl_addr;
							OP_SET_WRITE: wr_ptr_q <= ctrl_addr;
							OP_REG_WRITE: begin
								case (data_byte[2:0])
									REG_MODE0:   mode_ctrl_q[2] <= latched_q[1];
									// M3 lives in register zero; bit two here is ignored.
									REG_MODE1:   mode_ctrl_q <= {latched_q[7:3], mode_ctrl_q[2],
										latched_q[1:0]};
									REG_NAME:    raw_q[3:0]   <= latched_q[3:0];
									REG_COLOR:   raw_q[11:4]  <= latched_q;
									REG_PATTERN: raw_q[14:12] <= latched_q[2:0];
									REG_ATTR:    raw_q[21:15] <= latched_q[6:0];
									REG_SPRPAT:  raw_q[24:22] <= latched_q[2:0];
									default:     colours_q    <= latched_q;
								endcase
							end
							default: ;
						endcase
					end
				end
				CMD_DATA_WRITE: begin
					wr_ptr_q <= PTR_W'(wr_addr_inc);
					phase_q  <= 1'b0;
				end
				CMD_DATA_READ: begin
					rd_ptr_q <= PTR_W'(rd_addr_inc);
					phase_q  <= 1'b0;
				end
				CMD_STATUS: begin
					status_q <= '0;
					phase_q  <= 1'b0;
				end
				CMD_VBLANK: status_q[7] <= 1'b1;
				CMD_FIFTH: begin
					// The first fifth-sprite number is kept until the status is read.
					if (!status_q[6])
						status_q <= {status_q[7], 1'b1, status_q[5], sprite_number};
				end
				default: ;
			endcase
		end
	end

endmodule

/* rtl/vdpcpu_vram.sv */
// Video RAM with one write port and a registered read port.
module vdpcpu_vram import vdpcpu_pkg::*; #(
	parameter int VRAM_DEPTH = VRAM_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  vram_req_t  req,
	output logic [7:0] rdata
);

	localparam int AW = $clog2(VRAM_DEPTH);

	logic [7:0]    mem [VRAM_DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] addr;

	assign addr  = req.addr[AW-1:0];
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[addr] <= req.wdata;
		if (req.rd_en)
			rdata_q <= mem[addr];
	end

endmodule

/* rtl/vdpcpu_decode.sv */
// Decodes the display registers into mode, table bases, sprite size and colours.
module vdpcpu_decode import vdpcpu_pkg::*; (
	input  vdp_regs_t        regs,
	output logic [1:0]       video_mode,
	output logic             display_enable,
	output logic             interrupt_enable,
	output logic [PTR_W-1:0] name_base,
	output logic [PTR_W-1:0] pattern_base,
	output logic [PTR_W-1:0] color_base,
	output logic [PTR_W-1:0] sprite_attr_base,
	output logic [PTR_W-1:0] sprite_pattern_base,
	output logic [5:0]       sprite_size,
	output logic [3:0]       text_color,
	output logic [3:0]       backdrop_color
);

	logic [2:0] pat_field;
	logic [7:0] col_field;

	always_comb begin
		if (regs.mode_ctrl[4])
			video_mode = MODE_TEXT;
		else if (regs.mode_ctrl[3])
			video_mode = MODE_MC;
		else if (regs.mode_ctrl[2])
			video_mode = MODE_G2;
		else
			video_mode = MODE_G1;
	end

	// Graphics two keeps only the top bit of the pattern and colour fields.
	assign pat_field = (video_mode == MODE_G2) ? {regs.raw_tables[14], 2'b00}
		: regs.raw_tables[14:12];
	assign col_field = (video_mode == MODE_G2) ? {regs.raw_tables[11], 7'b0}
		: regs.raw_tables[11:4];

	assign display_enable      = regs.mode_ctrl[6];
	assign interrupt_enable    = regs.mode_ctrl[5];
	assign name_base           = {regs.raw_tables[3:0], 10'b0};
	assign pattern_base        = {pat_field, 11'b0};
	assign color_base          = {col_field, 6'b0};
	assign sprite_attr_base    = {regs.raw_tables[21:15], 7'b0};
	assign sprite_pattern_base = {regs.raw_tables[24:22], 11'b0};
	assign text_color          = regs.colours[7:4];
	assign backdrop_color      = regs.colours[3:0];

	always_comb begin
		case (regs.mode_ctrl[1:0])
			2'b00:   sprite_size = 6'd8;
			2'b11:   sprite_size = 6'd32;
			default: sprite_size = 6'd16;
		endcase
	end

endmodule

/* rtl/vdpcpu_checker.sv */
// Port-level checks for the CPU port, attached to the top level by a bind.
module vdpcpu_checker import vdpcpu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// A stalled result keeps its contents until the transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input side only stalls while a finished result waits on the output side.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:82] == 6'd8 || m_tdata[87:82] == 6'd16 ||
			m_tdata[87:82] == 6'd32)
		else $error("sprite size out of range");

	// Graphics two masks the pattern and colour bases down to their top bit.
	a_g2_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9:8] == MODE_G2 |->
			m_tdata[38:26] == 13'd0 && m_tdata[52:40] == 13'd0)
		else $error("graphics two base not masked");

endmodule

bind vdp_cpu_port_interface vdpcpu_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
